/* rtl/erc_pkg.sv */
// Shared types and constants for the eight-register core.
// Used by erc_alu, erc_wrap and eight_register_risc_core_unit.
package erc_pkg;

    localparam int XLEN      = 32;
    localparam int VAL_W     = 33;
    localparam int REG_COUNT = 8;
    localparam int RIDX_W    = 3;
    localparam int PORT_AW   = 16;

    typedef enum logic [2:0] {
        OP_ADD  = 3'b000,
        OP_NAND = 3'b001,
        OP_LW   = 3'b010,
        OP_SW   = 3'b011,
        OP_BEQ  = 3'b100,
        OP_JALR = 3'b101,
        OP_HALT = 3'b110,
        OP_NOOP = 3'b111
    } t_opcode;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_NAND,
        ALU_EQ
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_EXEC,
        S_BR,
        S_AWRAP,
        S_LWAIT,
        S_LWRAP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                bad_opcode;
        logic                reg_written;
        logic [RIDX_W-1:0]   reg_index;
        logic [XLEN-1:0]     reg_value;
        logic                mem_written;
        logic [PORT_AW-1:0]  mem_address;
        logic [XLEN-1:0]     mem_value;
    } t_result;

endpackage

/* rtl/erc_alu.sv */
// Shared arithmetic unit: add, nand and equality compare on 33-bit operands.
// Depends on erc_pkg.
module erc_alu (
    input  erc_pkg::t_alu_op              i_op,
    input  logic signed [erc_pkg::VAL_W-1:0] i_a,
    input  logic signed [erc_pkg::VAL_W-1:0] i_b,
    output logic signed [erc_pkg::VAL_W-1:0] o_result,
    output logic                          o_eq
);
    import erc_pkg::*;

    always_comb begin
        o_eq = (i_a == i_b);
        case (i_op)
            ALU_ADD:  o_result = i_a + i_b;
            ALU_NAND: o_result = {1'b0, ~(i_a[XLEN-1:0] & i_b[XLEN-1:0])};
            ALU_EQ:   o_result = '0;
            default:  o_result = '0;
        endcase
    end

endmodule

/* rtl/erc_wrap.sv */
// Address wrap unit: signed value modulo MEM_WORDS.
// Power-of-two depth masks the low bits; otherwise a reciprocal multiply pipeline.
// Depends on erc_pkg.
module erc_wrap #(
    parameter int MEM_WORDS = 65536
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [erc_pkg::VAL_W-1:0] i_value,
    output logic                             o_done,
    output logic [$clog2(MEM_WORDS)-1:0]     o_addr
);
    import erc_pkg::*;

    localparam int AW      = $clog2(MEM_WORDS);
    localparam bit IS_POW2 = ((MEM_WORDS & (MEM_WORDS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic          r_done;
            logic [AW-1:0] r_addr;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_addr <= i_value[AW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_addr = r_addr;
        end else begin : g_recip
            // quotient = (mag * ceil(2**SH / MEM_WORDS)) >> SH, exact for any 32-bit mag
            localparam int          SH       = 32 + AW;
            localparam logic [64:0] POW_SH   = 65'(1) << SH;
            localparam logic [64:0] RECIP    = (POW_SH + 65'(MEM_WORDS - 1)) / 65'(MEM_WORDS);
            localparam logic [31:0] RECIP_LO = RECIP[31:0];
            localparam logic        RECIP_HI = RECIP[32];
            localparam logic [31:0] M32      = 32'(MEM_WORDS);
            localparam logic [AW:0] MW       = (AW+1)'(MEM_WORDS);

            logic [5:0]        r_pipe;
            logic              r_neg;
            logic [31:0]       r_mag;
            logic [63:0]       r_prod;
            logic [31:0]       r_quo;
            logic [31:0]       r_qm;
            logic [AW-1:0]     r_raw;
            logic [AW-1:0]     r_addr;
            logic [VAL_W-1:0]  abs_val;
            logic [64:0]       prod_sum;

            // magnitude of every wrapped value stays below 2**32
            assign abs_val  = i_value[VAL_W-1] ? -i_value : i_value;
            assign prod_sum = {1'b0, r_prod} + (RECIP_HI ? {1'b0, r_mag, 32'b0} : 65'b0);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_pipe <= '0;
                end else begin
                    r_pipe <= {r_pipe[4:0], i_start};
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_neg <= i_value[VAL_W-1];
                    r_mag <= abs_val[31:0];
                end
                r_prod <= 64'(r_mag) * 64'(RECIP_LO);
                r_quo  <= 32'(prod_sum >> SH);
                r_qm   <= r_quo * M32;
                r_raw  <= AW'(r_mag - r_qm);
                if (r_neg && (r_raw != '0)) begin
                    r_addr <= AW'(MW - {1'b0, r_raw});
                end else begin
                    r_addr <= r_raw;
                end
            end

            assign o_done = r_pipe[5];
            assign o_addr = r_addr;
        end
    endgenerate

endmodule

/* rtl/eight_register_risc_core_unit.sv */
// Eight-register word machine: load items write memory, step items run one instruction.
// Load: wrap the address, write memory, give the result. Step: fetch, decode, execute;
// LW, SW and taken BEQ then wrap an address; a halted step only gives the result.
// One item at a time. A non-power-of-two MEM_WORDS wraps by reciprocal multiply, not mask.
// One synchronous word memory, one ALU and one wrap unit serve all steps.
// Reset clears pc, halt flag and registers; memory is undefined until written.
module eight_register_risc_core_unit #(
    parameter int MEM_WORDS = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_mode,
    input  logic [15:0]         i_load_address,
    input  logic signed [31:0]  i_load_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [15:0]         o_pc_after,
    output logic                o_halted,
    output logic                o_bad_opcode,
    output logic                o_reg_written,
    output logic [2:0]          o_reg_index,
    output logic signed [31:0]  o_reg_value,
    output logic                o_mem_written,
    output logic [15:0]         o_mem_address,
    output logic signed [31:0]  o_mem_value
);
    import erc_pkg::*;

    localparam int            AW      = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] PC_LAST = AW'(MEM_WORDS - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_pc, n_pc;
    logic                r_halt, n_halt;
    logic [XLEN-1:0]     r_rf [REG_COUNT];
    logic [XLEN-1:0]     r_ins, n_ins;
    logic [XLEN-1:0]     r_va, n_va;
    logic [XLEN-1:0]     r_vb, n_vb;
    logic [XLEN-1:0]     r_ldata, n_ldata;
    t_result             r_res, n_res;

    logic [XLEN-1:0]     r_mem [MEM_WORDS];
    logic [XLEN-1:0]     r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [XLEN-1:0]     mem_wdata;
    logic [AW-1:0]       mem_raddr;

    logic                rf_we;
    logic [RIDX_W-1:0]   rf_wa;
    logic [XLEN-1:0]     rf_wd;

    t_alu_op             alu_op;
    logic signed [VAL_W-1:0] alu_a, alu_b, alu_res;
    logic                alu_eq;

    logic                wrap_start;
    logic signed [VAL_W-1:0] wrap_value;
    logic                wrap_done;
    logic [AW-1:0]       wrap_addr;

    t_opcode             op;
    logic [AW-1:0]       pc_inc;
    logic [VAL_W-1:0]    off_ext;
    logic [VAL_W-1:0]    va_ext;
    logic [VAL_W-1:0]    vb_ext;

    erc_alu u_alu (
        .i_op     (alu_op),
        .i_a      (alu_a),
        .i_b      (alu_b),
        .o_result (alu_res),
        .o_eq     (alu_eq)
    );

    erc_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wrap_start),
        .i_value (wrap_value),
        .o_done  (wrap_done),
        .o_addr  (wrap_addr)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_halt  <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++) begin
                r_rf[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_halt  <= n_halt;
            if (rf_we) begin
                r_rf[rf_wa] <= rf_wd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ins   <= n_ins;
        r_va    <= n_va;
        r_vb    <= n_vb;
        r_ldata <= n_ldata;
        r_res   <= n_res;
    end

    assign op      = t_opcode'(r_ins[24:22]);
    assign pc_inc  = (r_pc == PC_LAST) ? '0 : r_pc + 1'b1;
    assign off_ext = {{(VAL_W-16){r_ins[15]}}, r_ins[15:0]};
    assign va_ext  = {r_va[XLEN-1], r_va};
    assign vb_ext  = {r_vb[XLEN-1], r_vb};

    always_comb begin
        n_state    = r_state;
        n_pc       = r_pc;
        n_halt     = r_halt;
        n_ins      = r_ins;
        n_va       = r_va;
        n_vb       = r_vb;
        n_ldata    = r_ldata;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = wrap_addr;
        mem_wdata  = r_ldata;
        mem_raddr  = r_pc;
        rf_we      = 1'b0;
        rf_wa      = r_ins[2:0];
        rf_wd      = alu_res[XLEN-1:0];
        alu_op     = ALU_ADD;
        alu_a      = va_ext;
        alu_b      = vb_ext;
        wrap_start = 1'b0;
        wrap_value = alu_res;
        o_ready    = 1'b0;
        o_valid    = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_res = '0;
                    if (!i_mode) begin
                        n_ldata    = i_load_data;
                        wrap_start = 1'b1;
                        wrap_value = VAL_W'(i_load_address);
                        n_state    = S_LWRAP;
                    end else if (r_halt) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_DEC;
                    end
                end
            end
            S_DEC: begin
                n_ins   = r_rdata;
                n_va    = r_rf[r_rdata[21:19]];
                n_vb    = r_rf[r_rdata[18:16]];
                n_state = S_EXEC;
            end
            S_EXEC: begin
                case (op)
                    OP_ADD, OP_NAND: begin
                        alu_op            = (op == OP_ADD) ? ALU_ADD : ALU_NAND;
                        rf_we             = 1'b1;
                        n_res.reg_written = 1'b1;
                        n_res.reg_index   = r_ins[2:0];
                        n_res.reg_value   = alu_res[XLEN-1:0];
                        n_pc              = pc_inc;
                        n_state           = S_OUT;
                    end
                    OP_LW, OP_SW: begin
                        alu_b      = off_ext;
                        wrap_start = 1'b1;
                        n_state    = S_AWRAP;
                    end
                    OP_BEQ: begin
                        alu_op = ALU_EQ;
                        if (alu_eq) begin
                            n_state = S_BR;
                        end else begin
                            n_pc    = pc_inc;
                            n_state = S_OUT;
                        end
                    end
                    OP_JALR: begin
                        n_res.bad_opcode = 1'b1;
                        n_pc             = pc_inc;
                        n_state          = S_OUT;
                    end
                    OP_HALT: begin
                        n_halt  = 1'b1;
                        n_pc    = pc_inc;
                        n_state = S_OUT;
                    end
                    default: begin
                        n_pc    = pc_inc;
                        n_state = S_OUT;
                    end
                endcase
            end
            S_BR: begin
                alu_a      = VAL_W'(pc_inc);
                alu_b      = off_ext;
                wrap_start = 1'b1;
                n_state    = S_AWRAP;
            end
            S_AWRAP: begin
                mem_raddr = wrap_addr;
                if (wrap_done) begin
                    case (op)
                        OP_BEQ: begin
                            n_pc    = wrap_addr;
                            n_state = S_OUT;
                        end
                        OP_SW: begin
                            mem_we            = 1'b1;
                            mem_wdata         = r_vb;
                            n_res.mem_written = 1'b1;
                            n_res.mem_address = PORT_AW'(wrap_addr);
                            n_res.mem_value   = r_vb;
                            n_pc              = pc_inc;
                            n_state           = S_OUT;
                        end
                        default: begin
                            n_state = S_LWAIT;
                        end
                    endcase
                end
            end
            S_LWAIT: begin
                rf_we             = 1'b1;
                rf_wa             = r_ins[18:16];
                rf_wd             = r_rdata;
                n_res.reg_written = 1'b1;
                n_res.reg_index   = r_ins[18:16];
                n_res.reg_value   = r_rdata;
                n_pc              = pc_inc;
                n_state           = S_OUT;
            end
            S_LWRAP: begin
                if (wrap_done) begin
                    mem_we            = 1'b1;
                    n_res.mem_written = 1'b1;
                    n_res.mem_address = PORT_AW'(wrap_addr);
                    n_res.mem_value   = r_ldata;
                    n_state           = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_pc_after    = PORT_AW'(r_pc);
    assign o_halted      = r_halt;
    assign o_bad_opcode  = r_res.bad_opcode;
    assign o_reg_written = r_res.reg_written;
    assign o_reg_index   = r_res.reg_index;
    assign o_reg_value   = r_res.reg_value;
    assign o_mem_written = r_res.mem_written;
    assign o_mem_address = r_res.mem_address;
    assign o_mem_value   = r_res.mem_value;

endmodule
